// ----- rtl/core/lebuf_pkg.sv -----
// Package for the line-editing receive buffer: payload structs, store size
// and character codes. No dependencies.
`default_nettype none

package lebuf_pkg;

  // Store size and pointer width
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // Character codes
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_SP  = 8'd32;

  // Request and result kinds
  localparam logic REQ_CHAR    = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
  } lebuf_req_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_char;
    logic       last_of_run;
  } lebuf_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/line_edit_receive_buffer.sv -----
// Line-editing receive buffer: top level with pointer logic and result sequencer.
// Depends on lebuf_pkg and lebuf_ram.
`default_nettype none

// Usage
//   in channel (in_valid_i/in_ready_o/in_i): a received character (req_type 0)
//   or a one-shot read request (req_type 1). out channel (out_valid_o/
//   out_ready_i/out_o): echo characters and delivered characters, with
//   last_of_run on the final result of each input item. Items that cause no
//   result (DEL on an empty line, a character at a full store, a read request
//   with nothing committed) produce no transfer on the out channel.
//   The first result of an item passes the read stage, then the result
//   register (the store read happens at the transfer edge, the result
//   register loads when the read stage moves on to the sequencer).
//   An item that causes N results holds the result register until all N
//   have transferred: DEL three, a stored character with delivery two, any
//   other result-causing item one; while they drain, one more item is taken.
//   The store has a single write port and a single read port; the write of a
//   character and the read of a delivery happen in the cycle of the transfer.
//   Reset clears pointers, the wait flag and all valid flags; the store keeps
//   its contents and needs no clearing pass, so the block is ready at once.
//   When the receiver stalls, results hold in the result register, one
//   further item waits in the read stage, and then in_ready_o drops.
module line_edit_receive_buffer
  import lebuf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire lebuf_req_t in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output lebuf_rsp_t      out_o
);

  typedef enum logic [1:0] {
    OP_ECHO,
    OP_ERASE,
    OP_DELIVER
  } op_e;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ZERO = '0;

  // Pointer state
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] cm_ptr_q, cm_ptr_d;
  logic             waiting_q, waiting_d;

  // Read stage
  logic       s1_valid_q, s1_valid_d;
  op_e        s1_op_q, s1_op_d;
  logic [7:0] s1_ch_q, s1_ch_d;
  logic       s1_dlv_q, s1_dlv_d;
  logic       s1_fwd_q, s1_fwd_d;

  // Result sequencer
  logic [1:0] em_cnt_q;
  lebuf_rsp_t slot0_q, slot1_q, slot2_q;

  logic       in_xfer, out_xfer, em_free, s1_move;
  logic       mem_we, mem_re;
  logic [7:0] mem_wdata, mem_rdata, dlv_ch;

  logic [PTR_W-1:0] wr_inc, wr_dec, rd_inc, cm_new;
  logic [7:0]       st_ch;

  assign em_free    = (em_cnt_q == 2'd0) || ((em_cnt_q == 2'd1) && out_ready_i);
  assign s1_move    = s1_valid_q && em_free;
  assign in_ready_o = !s1_valid_q || em_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_o && out_ready_i;

  assign wr_inc = (wr_ptr_q == PTR_LAST) ? PTR_ZERO : wr_ptr_q + 1'b1;
  assign wr_dec = (wr_ptr_q == PTR_ZERO) ? PTR_LAST : wr_ptr_q - 1'b1;
  assign rd_inc = (rd_ptr_q == PTR_LAST) ? PTR_ZERO : rd_ptr_q + 1'b1;
  assign st_ch  = (in_i.rx_char == CH_CR) ? CH_LF : in_i.rx_char;
  assign cm_new = (in_i.rx_char == CH_CR) ? wr_inc : cm_ptr_q;

  // Decode an accepted item: update pointers, write and read the store
  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    cm_ptr_d   = cm_ptr_q;
    waiting_d  = waiting_q;
    s1_valid_d = s1_valid_q && !s1_move;
    s1_op_d    = s1_op_q;
    s1_ch_d    = s1_ch_q;
    s1_dlv_d   = s1_dlv_q;
    s1_fwd_d   = s1_fwd_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = st_ch;
    if (in_xfer) begin
      s1_valid_d = 1'b0;
      s1_dlv_d   = 1'b0;
      s1_fwd_d   = 1'b0;
      s1_ch_d    = st_ch;
      if (in_i.req_type == REQ_READ) begin
        s1_op_d = OP_DELIVER;
        if (cm_ptr_q != rd_ptr_q) begin
          s1_valid_d = 1'b1;
          s1_dlv_d   = 1'b1;
          mem_re     = 1'b1;
          rd_ptr_d   = rd_inc;
          waiting_d  = 1'b0;
        end else begin
          waiting_d = 1'b1;
        end
      end else if (in_i.rx_char == CH_DEL) begin
        s1_op_d = OP_ERASE;
        if (wr_ptr_q != cm_ptr_q) begin
          s1_valid_d = 1'b1;
          wr_ptr_d   = wr_dec;
        end
      end else begin
        s1_op_d = OP_ECHO;
        if (wr_inc != rd_ptr_q) begin
          s1_valid_d = 1'b1;
          mem_we     = 1'b1;
          wr_ptr_d   = wr_inc;
          cm_ptr_d   = cm_new;
          if (waiting_q && (cm_new != rd_ptr_q)) begin
            s1_dlv_d  = 1'b1;
            // Delivering the character written in this same transfer
            s1_fwd_d  = (rd_ptr_q == wr_ptr_q);
            mem_re    = 1'b1;
            rd_ptr_d  = rd_inc;
            waiting_d = 1'b0;
          end
        end
      end
    end
  end

  lebuf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign dlv_ch = s1_fwd_q ? s1_ch_q : mem_rdata;

  // Hold pointers and the read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cm_ptr_q   <= '0;
      waiting_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_ECHO;
      s1_dlv_q   <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      cm_ptr_q   <= cm_ptr_d;
      waiting_q  <= waiting_d;
      s1_valid_q <= s1_valid_d;
      s1_op_q    <= s1_op_d;
      s1_dlv_q   <= s1_dlv_d;
      s1_fwd_q   <= s1_fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q <= s1_ch_d;
  end

  // Load result slots from the read stage, shift them out on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_cnt_q <= 2'd0;
    end else if (s1_move) begin
      case (s1_op_q)
        OP_ECHO:    em_cnt_q <= s1_dlv_q ? 2'd2 : 2'd1;
        OP_ERASE:   em_cnt_q <= 2'd3;
        OP_DELIVER: em_cnt_q <= 2'd1;
        default:    em_cnt_q <= 2'd0;
      endcase
    end else if (out_xfer) begin
      em_cnt_q <= em_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      case (s1_op_q)
        OP_ECHO: begin
          slot0_q <= '{out_kind: KIND_ECHO, out_char: s1_ch_q, last_of_run: !s1_dlv_q};
          slot1_q <= '{out_kind: KIND_DELIVER, out_char: dlv_ch, last_of_run: 1'b1};
        end
        OP_ERASE: begin
          slot0_q <= '{out_kind: KIND_ECHO, out_char: CH_BS, last_of_run: 1'b0};
          slot1_q <= '{out_kind: KIND_ECHO, out_char: CH_SP, last_of_run: 1'b0};
          slot2_q <= '{out_kind: KIND_ECHO, out_char: CH_BS, last_of_run: 1'b1};
        end
        OP_DELIVER: begin
          slot0_q <= '{out_kind: KIND_DELIVER, out_char: dlv_ch, last_of_run: 1'b1};
        end
        default: begin
          slot0_q <= slot0_q;
        end
      endcase
    end else if (out_xfer) begin
      slot0_q <= slot1_q;
      slot1_q <= slot2_q;
    end
  end

  assign out_valid_o = (em_cnt_q != 2'd0);
  assign out_o       = slot0_q;

  // The read stage never drops an entry while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !em_free) |=> s1_valid_q)
    else $error("read stage lost an entry while stalled");

  // Only the final slot carries the end-of-run mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last_of_run == (em_cnt_q == 2'd1)))
    else $error("end-of-run mark on wrong result");

  // A delivery is never pending while the reader still counts as waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mem_re) |=> (!waiting_q && s1_valid_q && s1_dlv_q))
    else $error("delivery read without matching read-stage entry");

  // A forwarded delivery only follows a store write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> (s1_dlv_q && s1_op_q == OP_ECHO))
    else $error("forwarded delivery without a stored character");

endmodule

`default_nettype wire

// ----- rtl/core/lebuf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lebuf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
